// ===== hw/rtl/batched_matrix_multiply_unit_assert.svh =====
// Assertion macros for the batched matrix multiply unit checkers.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef BATCHED_MATRIX_MULTIPLY_UNIT_ASSERT_SVH
`define BATCHED_MATRIX_MULTIPLY_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define BMM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bmm assertion failed");

// next-cycle implication, disabled in reset
`define BMM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bmm assertion failed");

`endif

// ===== hw/rtl/bmm_pkg.sv =====
// Shared constants, codes and types of the batched matrix multiply unit.
// No dependencies.
package bmm_pkg;

  localparam int unsigned MAX_BATCH = 16;
  localparam int unsigned MAX_ROWS  = 8;
  localparam int unsigned MAX_INNER = 8;
  localparam int unsigned MAX_COLS  = 8;

  localparam int unsigned A_DEPTH = MAX_BATCH * MAX_ROWS * MAX_INNER;
  localparam int unsigned B_DEPTH = MAX_BATCH * MAX_INNER * MAX_COLS;
  localparam int unsigned A_AW    = $clog2(A_DEPTH);
  localparam int unsigned B_AW    = $clog2(B_DEPTH);

  // item fields
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned BATCH_W = 4;
  localparam int unsigned ROW_W   = 3;
  localparam int unsigned COL_W   = 3;
  localparam int unsigned ELEM_W  = 32;
  localparam int unsigned OUT_W   = 64;

  localparam int unsigned BATCH_LSB = 0;
  localparam int unsigned ROW_LSB   = BATCH_LSB + BATCH_W;
  localparam int unsigned COL_LSB   = ROW_LSB + ROW_W;
  localparam int unsigned VALUE_LSB = COL_LSB + COL_W;
  localparam int unsigned IN_DATA_W = ((VALUE_LSB + ELEM_W + 7) / 8) * 8;

  // configuration
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned NB_W       = 5;
  localparam int unsigned SIZE_W     = 4;

  // arithmetic
  localparam int unsigned PROD_W = 2 * ELEM_W;
  localparam int unsigned ACC_W  = PROD_W + $clog2(MAX_INNER) + 1;
  localparam int unsigned CNT_W  = $clog2(MAX_INNER + 1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WR_A = 2'd0,
    FUNC_WR_B = 2'd1,
    FUNC_RD   = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BATCH = 2'd0,
    CFG_ROWS  = 2'd1,
    CFG_INNER = 2'd2,
    CFG_COLS  = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ISSUE = 3'b010,
    S_DRAIN = 3'b100
  } seq_state_e;

  typedef struct packed {
    logic clear;     // zero the accumulator
    logic in_valid;  // operands on the inputs this cycle
  } mac_ctrl_t;

endpackage

// ===== hw/rtl/bmm_ram.sv =====
// Simple dual-port RAM, one write and one registered read port.
// Generic; no dependencies.
module bmm_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hw/rtl/bmm_mac.sv =====
// Shared multiply-accumulate unit: registered 32x32 product, wide accumulator,
// saturation to signed Q32.32. Depends on bmm_pkg.
module bmm_mac import bmm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mac_ctrl_t         ctrl_i,
  input  logic [ELEM_W-1:0] a_i,
  input  logic [ELEM_W-1:0] b_i,
  output logic              busy_o,
  output logic [OUT_W-1:0]  result_o
);

  logic                     prod_v_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic [ACC_W-OUT_W:0]     acc_hi;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else begin
      prod_v_q <= ctrl_i.in_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.in_valid) begin
      prod_q <= $signed(a_i) * $signed(b_i);
    end
    if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (prod_v_q) begin
      acc_q <= acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  assign busy_o = prod_v_q;

  // in range when all bits above the Q32.32 sign agree with it
  assign acc_hi = acc_q[ACC_W-1:OUT_W-1];

  always_comb begin
    if ((&acc_hi) || !(|acc_hi)) begin
      result_o = acc_q[OUT_W-1:0];
    end else if (acc_q[ACC_W-1]) begin
      result_o = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      result_o = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

endmodule

// ===== hw/rtl/bmm_seq.sv =====
// Sequencer: size registers, index checks, store addressing, the inner-term
// walk and the output register. Depends on bmm_pkg.
module bmm_seq import bmm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic [FUNC_W-1:0]     s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_W-1:0]      m_axis_tdata_o,
  output logic                  m_axis_tuser_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  a_we_o,
  output logic [A_AW-1:0]       a_waddr_o,
  output logic [A_AW-1:0]       a_raddr_o,
  output logic                  b_we_o,
  output logic [B_AW-1:0]       b_waddr_o,
  output logic [B_AW-1:0]       b_raddr_o,
  output logic [ELEM_W-1:0]     wdata_o,
  output mac_ctrl_t             mac_ctrl_o,
  input  logic                  mac_busy_i,
  input  logic [OUT_W-1:0]      mac_result_i
);

  seq_state_e state_q, state_d;

  logic [NB_W-1:0]   batch_cnt_q;
  logic [SIZE_W-1:0] rows_q, inner_q, cols_q;
  logic [SIZE_W-1:0] q_eff;

  func_e              in_func;
  logic [BATCH_W-1:0] in_batch;
  logic [ROW_W-1:0]   in_row;
  logic [COL_W-1:0]   in_col;

  logic [BATCH_W-1:0] item_batch_q;
  logic [ROW_W-1:0]   item_row_q;
  logic [COL_W-1:0]   item_col_q;
  logic [CNT_W-1:0]   l_q, l_d;
  logic               rd_v_q;

  logic b_ok, row_lt_p, row_lt_q, col_lt_q, col_lt_r, item_ok;
  logic accept, good_read, out_free, last_term, done;

  logic             out_valid_q;
  logic [OUT_W-1:0] out_data_q;
  logic             out_status_q;

  assign in_func  = func_e'(s_axis_tuser_i);
  assign in_batch = s_axis_tdata_i[BATCH_LSB +: BATCH_W];
  assign in_row   = s_axis_tdata_i[ROW_LSB +: ROW_W];
  assign in_col   = s_axis_tdata_i[COL_LSB +: COL_W];
  assign wdata_o  = s_axis_tdata_i[VALUE_LSB +: ELEM_W];

  // size registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_cnt_q <= NB_W'(16);
      rows_q      <= SIZE_W'(8);
      inner_q     <= SIZE_W'(8);
      cols_q      <= SIZE_W'(8);
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_BATCH: batch_cnt_q <= cfg_data_i[NB_W-1:0];
        CFG_ROWS:  rows_q      <= cfg_data_i[SIZE_W-1:0];
        CFG_INNER: inner_q     <= cfg_data_i[SIZE_W-1:0];
        CFG_COLS:  cols_q      <= cfg_data_i[SIZE_W-1:0];
        default:   ;
      endcase
    end
  end

  // idx < min(reg, cap) split into two compares
  assign b_ok     = ({1'b0, in_batch} < batch_cnt_q) && (int'(in_batch) < MAX_BATCH);
  assign row_lt_p = ({1'b0, in_row} < rows_q)  && (int'(in_row) < MAX_ROWS);
  assign row_lt_q = ({1'b0, in_row} < inner_q) && (int'(in_row) < MAX_INNER);
  assign col_lt_q = ({1'b0, in_col} < inner_q) && (int'(in_col) < MAX_INNER);
  assign col_lt_r = ({1'b0, in_col} < cols_q)  && (int'(in_col) < MAX_COLS);

  always_comb begin
    case (in_func)
      FUNC_WR_A: item_ok = b_ok && row_lt_p && col_lt_q;
      FUNC_WR_B: item_ok = b_ok && row_lt_q && col_lt_r;
      FUNC_RD:   item_ok = b_ok && row_lt_p && col_lt_r;
      default:   item_ok = 1'b0;
    endcase
  end

  assign q_eff = (int'(inner_q) > MAX_INNER) ? SIZE_W'(MAX_INNER) : inner_q;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE) && out_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign good_read       = accept && (in_func == FUNC_RD) && item_ok;

  // writes go straight to the stores in the transfer cycle
  assign a_we_o    = accept && (in_func == FUNC_WR_A) && item_ok;
  assign b_we_o    = accept && (in_func == FUNC_WR_B) && item_ok;
  assign a_waddr_o = A_AW'((int'(in_batch) * MAX_ROWS + int'(in_row)) * MAX_INNER
                           + int'(in_col));
  assign b_waddr_o = B_AW'((int'(in_batch) * MAX_INNER + int'(in_row)) * MAX_COLS
                           + int'(in_col));

  assign a_raddr_o = A_AW'((int'(item_batch_q) * MAX_ROWS + int'(item_row_q)) * MAX_INNER
                           + int'(l_q));
  assign b_raddr_o = B_AW'((int'(item_batch_q) * MAX_INNER + int'(l_q)) * MAX_COLS
                           + int'(item_col_q));

  assign last_term = (int'(l_q) + 1) >= int'(q_eff);

  always_comb begin
    state_d = state_q;
    l_d     = l_q;
    done    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (good_read) begin
          l_d     = '0;
          state_d = (q_eff == '0) ? S_DRAIN : S_ISSUE;
        end
      end
      S_ISSUE: begin
        l_d = l_q + 1'b1;
        if (last_term) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // wait for the last product to land in the accumulator
        if (!rd_v_q && !mac_busy_i && out_free) begin
          done    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      l_q     <= '0;
      rd_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      l_q     <= l_d;
      rd_v_q  <= (state_q == S_ISSUE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (good_read) begin
      item_batch_q <= in_batch;
      item_row_q   <= in_row;
      item_col_q   <= in_col;
    end
  end

  assign mac_ctrl_o.clear    = good_read;
  assign mac_ctrl_o.in_valid = rd_v_q;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((accept && !good_read) || done) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !good_read) begin
      out_data_q   <= '0;
      out_status_q <= !item_ok;
    end else if (done) begin
      out_data_q   <= mac_result_i;
      out_status_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_status_q;

endmodule

// ===== hw/rtl/batched_matrix_multiply_unit.sv =====
// Top level of the batched matrix multiply unit.
// Depends on bmm_pkg, bmm_ram, bmm_mac and bmm_seq.
//
// Usage:
//   Input stream s_axis_*: tuser = func (write A, write B, read product),
//   tdata = batch, row, column and a Q16.16 element. Output stream m_axis_*:
//   tdata = Q32.32 product (zero for writes and flagged items), tuser = status,
//   set when an index lies outside the configured sizes or func is unused.
//   Config channel cfg_*: index 0..3 selects batch count, rows of A, inner
//   size, columns of B; always ready, write only while the block is idle.
// Timing:
//   A write (or any flagged item) has its result valid in the cycle after the
//   transfer. A good read walks q inner terms through one shared multiplier
//   and accumulator, one term per cycle; each term passes the store read,
//   multiply and accumulate registers, and the sum then goes to the output
//   register; the next item may transfer once the result is valid. Input
//   ready is low while a read is in progress.
// Reset / stall:
//   Reset sets all sizes to their maximum and empties the output register;
//   store contents are undefined until written. A held output register
//   blocks the next item only until the result transfers.
module batched_matrix_multiply_unit import bmm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // batch_index[3:0], row_index[6:4], col_index[9:7], element_value[41:10], zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // func[1:0]
  input  logic [FUNC_W-1:0]     s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // product_value[63:0]
  output logic [OUT_W-1:0]      m_axis_tdata_o,
  // status[0]
  output logic                  m_axis_tuser_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic              a_we, b_we;
  logic [A_AW-1:0]   a_waddr, a_raddr;
  logic [B_AW-1:0]   b_waddr, b_raddr;
  logic [ELEM_W-1:0] wdata, a_rdata, b_rdata;
  mac_ctrl_t         mac_ctrl;
  logic              mac_busy;
  logic [OUT_W-1:0]  mac_result;

  bmm_seq u_seq (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .a_we_o       (a_we),
    .a_waddr_o    (a_waddr),
    .a_raddr_o    (a_raddr),
    .b_we_o       (b_we),
    .b_waddr_o    (b_waddr),
    .b_raddr_o    (b_raddr),
    .wdata_o      (wdata),
    .mac_ctrl_o   (mac_ctrl),
    .mac_busy_i   (mac_busy),
    .mac_result_i (mac_result)
  );

  bmm_ram #(.DEPTH(A_DEPTH), .WIDTH(ELEM_W)) u_a_store (
    .clk_i,
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (wdata),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  bmm_ram #(.DEPTH(B_DEPTH), .WIDTH(ELEM_W)) u_b_store (
    .clk_i,
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (wdata),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  bmm_mac u_mac (
    .clk_i,
    .rst_ni,
    .ctrl_i   (mac_ctrl),
    .a_i      (a_rdata),
    .b_i      (b_rdata),
    .busy_o   (mac_busy),
    .result_o (mac_result)
  );

endmodule

// ===== hw/rtl/bmm_checker.sv =====
// Port-level checker for the batched matrix multiply unit, bound to the top.
// Depends on bmm_pkg and batched_matrix_multiply_unit_assert.svh.
`include "batched_matrix_multiply_unit_assert.svh"

module bmm_checker import bmm_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic [FUNC_W-1:0]     s_axis_tuser_i,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_W-1:0]      m_axis_tdata_o,
  input logic                  m_axis_tuser_o,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o
);

  logic in_xfer;
  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;

  // a stalled result holds
  `BMM_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))

  // a flagged item never carries a value
  `BMM_ASSERT_IMP(a_flag_zero, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tdata_o == '0)

  // anything but a read answers in the next cycle with zero
  `BMM_ASSERT_NEXT(a_write_resp, in_xfer && (s_axis_tuser_i != FUNC_RD),
    m_axis_tvalid_o && (m_axis_tdata_o == '0))

  // after a transfer the block either answers or holds off the next item
  `BMM_ASSERT_NEXT(a_one_at_a_time, in_xfer, m_axis_tvalid_o || !s_axis_tready_o)

  // the config channel never back-pressures
  `BMM_ASSERT_IMP(a_cfg_ready, cfg_valid_i, cfg_ready_o)

endmodule

bind batched_matrix_multiply_unit bmm_checker u_bmm_checker (.*);
